// ----- hdl/priority_task_scheduler_semaphores_unit_macros.svh -----
// Assertion macros for the priority task scheduler
`ifndef PRIORITY_TASK_SCHEDULER_SEMAPHORES_UNIT_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_SEMAPHORES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) a |=> b) else $error(msg);
`else
`define PTS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PTS_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// ----- hdl/pts_pkg.sv -----
// Shared types and codes for the priority task scheduler
package pts_pkg;
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_P     = 3'd1;
    localparam logic [2:0] OP_PT    = 3'd2;
    localparam logic [2:0] OP_V     = 3'd3;
    localparam logic [2:0] OP_SLEEP = 3'd4;
    localparam logic [2:0] OP_YIELD = 3'd5;
    localparam int CFG_IDX_W = 3;
    localparam logic [15:0] SEM_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  sem_index;
        logic [15:0] ticks;
    } pts_in_t;

    typedef struct packed {
        logic [1:0]         running_task;
        logic               switched;
        logic               timed_out;
        logic               none_ready;
        logic signed [15:0] sem_value;
    } pts_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // latch input transaction
        logic exec;   // apply operation
        logic tick;   // process one task for tick
        logic scan;   // examine one task of the ring
        logic commit; // finish scheduling, build result
    } pts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic resched;
    } pts_sts_t;
endpackage

// ----- hdl/pts_datapath.sv -----
// Scheduler state, semaphore queues and one-task-a-cycle scan
module pts_datapath #(
    parameter int NUM_TASKS = 4,
    parameter int NUM_SEMS  = 4,
    parameter int TICK_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pts_pkg::pts_in_t  in_data,
    input  pts_pkg::pts_cmd_t cmd,
    input  logic [1:0]        step,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [7:0]        cfg_data,
    output pts_pkg::pts_sts_t sts,
    output pts_pkg::pts_out_t res
);
    import pts_pkg::*;

    logic [7:0]           prio_reg [4];
    logic [7:0]           start_reg [4];
    logic [1:0]           running_reg;
    logic [3:0]           blk_reg, slp_reg, tmo_reg;
    logic [TICK_BITS-1:0] left_reg [4];
    logic [1:0]           wsem_reg [4], link_reg [4];
    logic signed [15:0]   cnt_reg [4];
    logic [1:0]           head_reg [4], tail_reg [4];
    logic [3:0]           full_reg;
    pts_in_t              in_reg;
    logic [1:0]           cur_reg, best_reg;
    logic                 found_reg, resched_reg;

    logic [1:0]           s, cur, t, ts;
    logic                 sem_ok, rdy_cur;
    logic [TICK_BITS-1:0] tk, dec;
    logic signed [15:0]   cnt_dec;

    assign s      = in_reg.sem_index;
    assign cur    = cur_reg;
    assign sem_ok = 32'(s) < NUM_SEMS;
    assign rdy_cur = !blk_reg[cur] && !slp_reg[cur];
    assign tk = (TICK_BITS >= 16) ? TICK_BITS'(in_reg.ticks)
              : ((in_reg.ticks >> TICK_BITS) != 16'd0 ? '1 : TICK_BITS'(in_reg.ticks));
    assign cnt_dec = cnt_reg[s] - 16'sd1;
    assign t  = step;
    assign dec = left_reg[t] - 1'b1;
    // ring position for scan step
    always_comb begin
        logic [2:0] sum;
        sum = 3'(cur_reg) + 3'(step) + 3'd1;
        ts = (32'(sum) >= NUM_TASKS) ? 2'(32'(sum) - NUM_TASKS) : sum[1:0];
    end

    assign sts.is_tick = in_reg.operation == OP_TICK;
    assign sts.resched = resched_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
            blk_reg <= '0; slp_reg <= '0; tmo_reg <= '0; full_reg <= '0;
            resched_reg <= 1'b0; found_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                left_reg[i] <= '0; wsem_reg[i] <= '0; link_reg[i] <= '0;
                head_reg[i] <= '0; tail_reg[i] <= '0;
            end
            prio_reg[0] <= 8'd70; prio_reg[1] <= 8'd50;
            prio_reg[2] <= 8'd30; prio_reg[3] <= 8'd30;
            start_reg[0] <= 8'd0; start_reg[1] <= 8'd0;
            start_reg[2] <= 8'd0; start_reg[3] <= 8'd1;
            cnt_reg[0] <= 16'sd0; cnt_reg[1] <= 16'sd0;
            cnt_reg[2] <= 16'sd0; cnt_reg[3] <= 16'sd1;
        end else begin
            // configuration writes
            if (cfg_we) begin
                if (!cfg_idx[2]) prio_reg[cfg_idx[1:0]] <= cfg_data;
                else begin
                    start_reg[cfg_idx[1:0]] <= cfg_data;
                    if (32'(cfg_idx[1:0]) < NUM_SEMS && !full_reg[cfg_idx[1:0]])
                        cnt_reg[cfg_idx[1:0]] <= {8'd0, cfg_data};
                end
            end
            // latch transaction
            if (cmd.load) begin
                in_reg <= in_data;
                cur_reg <= running_reg;
                resched_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            // apply operation
            if (cmd.exec) begin
                case (in_reg.operation)
                    OP_TICK, OP_YIELD: resched_reg <= 1'b1;
                    OP_P, OP_PT: begin
                        if (sem_ok) begin
                            if (in_reg.operation == OP_PT) tmo_reg[cur] <= 1'b0;
                            if (rdy_cur) begin
                                cnt_reg[s] <= cnt_dec;
                                if (cnt_dec < 0) begin
                                    wsem_reg[cur] <= s;
                                    blk_reg[cur] <= 1'b1;
                                    if (in_reg.operation == OP_PT) begin
                                        slp_reg[cur] <= 1'b1;
                                        left_reg[cur] <= tk;
                                    end
                                    link_reg[cur] <= '0;
                                    if (full_reg[s]) link_reg[tail_reg[s]] <= cur;
                                    else begin
                                        head_reg[s] <= cur;
                                        full_reg[s] <= 1'b1;
                                    end
                                    tail_reg[s] <= cur;
                                    resched_reg <= 1'b1;
                                end
                            end
                        end
                    end
                    OP_V: begin
                        if (sem_ok) begin
                            if (cnt_reg[s] != $signed(SEM_MAX))
                                cnt_reg[s] <= cnt_reg[s] + 16'sd1;
                            if (full_reg[s]) begin
                                blk_reg[head_reg[s]] <= 1'b0;
                                slp_reg[head_reg[s]] <= 1'b0;
                                if (tail_reg[s] == head_reg[s]) full_reg[s] <= 1'b0;
                                else head_reg[s] <= link_reg[head_reg[s]];
                                if (prio_reg[head_reg[s]] > prio_reg[cur])
                                    resched_reg <= 1'b1;
                            end
                        end
                    end
                    OP_SLEEP: begin
                        if (rdy_cur) begin
                            slp_reg[cur] <= 1'b1;
                            left_reg[cur] <= tk;
                            resched_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            // count down one task; unlink it on timeout (queue is at most 4 deep)
            if (cmd.tick && 32'(t) < NUM_TASKS && slp_reg[t]) begin
                left_reg[t] <= dec;
                if (dec == '0) begin
                    slp_reg[t] <= 1'b0;
                    if (blk_reg[t]) begin
                        logic [1:0] q, p;
                        q = wsem_reg[t];
                        blk_reg[t] <= 1'b0;
                        tmo_reg[t] <= 1'b1;
                        if (cnt_reg[q] != $signed(SEM_MAX))
                            cnt_reg[q] <= cnt_reg[q] + 16'sd1;
                        if (full_reg[q]) begin
                            if (head_reg[q] == t) begin
                                if (tail_reg[q] == t) full_reg[q] <= 1'b0;
                                else head_reg[q] <= link_reg[t];
                            end else begin
                                p = head_reg[q];
                                for (int i = 0; i < 3; i++) begin
                                    if (p != tail_reg[q] && link_reg[p] == t) begin
                                        link_reg[p] <= link_reg[t];
                                        if (tail_reg[q] == t) tail_reg[q] <= p;
                                        p = tail_reg[q];
                                    end else if (p != tail_reg[q]) p = link_reg[p];
                                end
                            end
                        end
                    end
                end
            end
            // examine one task of the ring
            if (cmd.scan && 32'(step) < NUM_TASKS) begin
                if (!blk_reg[ts] && !slp_reg[ts] &&
                    (!found_reg || prio_reg[ts] > prio_reg[best_reg])) begin
                    best_reg <= ts;
                    found_reg <= 1'b1;
                end
            end
            // result
            if (cmd.commit) begin
                if (resched_reg && found_reg) running_reg <= best_reg;
                res.running_task <= (resched_reg && found_reg) ? best_reg : cur_reg;
                res.switched <= resched_reg && found_reg && best_reg != cur_reg;
                res.timed_out <= tmo_reg[(resched_reg && found_reg) ? best_reg : cur_reg];
                res.none_ready <= resched_reg && !found_reg;
                res.sem_value <= ((in_reg.operation == OP_P || in_reg.operation == OP_PT
                    || in_reg.operation == OP_V) && sem_ok) ? cnt_reg[s] : 16'sd0;
            end
        end
    end
endmodule

// ----- hdl/pts_controller.sv -----
// Sequencing state machine and output handshake for the scheduler
module pts_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pts_pkg::pts_sts_t sts,
    output pts_pkg::pts_cmd_t cmd,
    output logic [1:0]        step
);
    import pts_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_TICK = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       mv_reg, mv_next;

    assign step    = step_reg;
    assign m_valid = mv_reg;
    assign s_ready = (state_reg == ST_IDLE) && (!mv_reg || m_ready);

    // sequence one transaction
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                step_next = '0;
                if (sts.is_tick) state_next = ST_TICK;
                else begin
                    cmd.exec = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_TICK: begin
                cmd.tick = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    cmd.exec = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.commit = 1'b1;
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

// ----- hdl/priority_task_scheduler_semaphores_unit.sv -----
// Top level of the priority task scheduler with counting semaphores
// Usage:
//   s_valid/s_ready carry one operation transaction (operation, sem_index,
//   ticks); m_valid/m_ready carry the one result transaction it produces.
//   cfg_we/cfg_idx/cfg_data write priorities (0..3) and semaphore start
//   counts (4..7); write only while idle.
// Sequence:
//   A non-tick operation is applied, then each task of the ring is scanned
//   by priority and the result is registered to m_valid; a tick first counts
//   down and unlinks each task in turn, then does the same scan. One item is
//   in flight at a time; the next is accepted once the result register is
//   free or taken.
// Reset:
//   aresetn low at a clock edge clears all task and queue state, restores the
//   default priorities and start counts and loads the semaphore counters.
// Stall:
//   The result register holds while m_ready is low, and no new
//   transaction is accepted until the result is taken.
`include "priority_task_scheduler_semaphores_unit_macros.svh"
module priority_task_scheduler_semaphores_unit #(
    parameter int NUM_TASKS = 4,
    parameter int NUM_SEMS  = 4,
    parameter int TICK_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pts_pkg::pts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pts_pkg::pts_out_t m_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [7:0]        cfg_data
);
    import pts_pkg::*;

    pts_cmd_t   cmd;
    pts_sts_t   sts;
    logic [1:0] step;

    pts_controller u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .sts, .cmd, .step
    );

    pts_datapath #(
        .NUM_TASKS(NUM_TASKS), .NUM_SEMS(NUM_SEMS), .TICK_BITS(TICK_BITS)
    ) u_dp (
        .aclk, .aresetn, .in_data(s_data), .cmd, .step,
        .cfg_we, .cfg_idx, .cfg_data, .sts, .res(m_data)
    );

    `PTS_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, (m_valid && !m_ready) |-> !s_ready, "accept while result stalled")
    `PTS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, (s_valid && s_ready), !s_ready, "accept two in a row")
    `PTS_ASSERT_IMPL(a_cmd_onehot, aclk, aresetn, $onehot0({cmd.load, cmd.scan, cmd.commit}), "command overlap")
endmodule

// ----- sim/priority_task_scheduler_semaphores_unit_test.sv -----
// Self-checking testbench for the priority task scheduler with counting semaphores
`timescale 1ns / 1ps
module priority_task_scheduler_semaphores_unit_test;
    import pts_pkg::*;

    localparam int NTASK = 4;
    localparam int NSEM = 4;
    localparam logic [2:0] CFG_PRIO0 = 3'd0;
    localparam logic [2:0] CFG_START0 = 3'd4;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pts_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pts_out_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [7:0] cfg_data = '0;

    priority_task_scheduler_semaphores_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // scheduler image kept by the testbench
    logic [7:0] prio [NTASK];
    logic [7:0] start_cnt [NSEM];
    logic [1:0] cur_task;
    logic blk [NTASK];
    logic slp [NTASK];
    logic [15:0] slp_left [NTASK];
    logic [1:0] wsem [NTASK];
    logic [1:0] nxt [NTASK];
    logic tmo [NTASK];
    int sem_cnt [NSEM];
    logic [1:0] qhead [NSEM];
    logic [1:0] qtail [NSEM];
    logic qbusy [NSEM];

    pts_in_t pending_ops [$];
    pts_out_t expected_results [$];
    int mismatches = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit hold_tx = 1'b0;

    function automatic bit task_ready(int t);
        return !blk[t] && !slp[t];
    endfunction

    function automatic void model_reset();
        cur_task = '0;
        prio[0] = 8'd70; prio[1] = 8'd50; prio[2] = 8'd30; prio[3] = 8'd30;
        start_cnt[0] = 8'd0; start_cnt[1] = 8'd0; start_cnt[2] = 8'd0; start_cnt[3] = 8'd1;
        for (int i = 0; i < 4; i++) begin
            blk[i] = 1'b0; slp[i] = 1'b0; slp_left[i] = '0; wsem[i] = '0; nxt[i] = '0;
            tmo[i] = 1'b0; sem_cnt[i] = start_cnt[i]; qhead[i] = '0; qtail[i] = '0;
            qbusy[i] = 1'b0;
        end
    endfunction

    function automatic void model_config(logic [2:0] idx, logic [7:0] v);
        if (idx < CFG_START0) prio[idx] = v;
        else begin
            start_cnt[idx - CFG_START0] = v;
            if (!qbusy[idx - CFG_START0]) sem_cnt[idx - CFG_START0] = v;
        end
    endfunction

    function automatic void queue_push(int s, int t);
        nxt[t] = '0;
        if (qbusy[s]) nxt[qtail[s]] = 2'(t);
        else begin
            qhead[s] = 2'(t);
            qbusy[s] = 1'b1;
        end
        qtail[s] = 2'(t);
    endfunction

    function automatic void queue_unlink(int s, int t);
        logic [1:0] p;
        if (!qbusy[s]) return;
        if (qhead[s] == t) begin
            if (qtail[s] == t) qbusy[s] = 1'b0;
            else qhead[s] = nxt[t];
            return;
        end
        p = qhead[s];
        for (int i = 0; i < NTASK; i++) begin
            if (p == qtail[s]) return;
            if (nxt[p] == t) begin
                nxt[p] = nxt[t];
                if (qtail[s] == t) qtail[s] = p;
                return;
            end
            p = nxt[p];
        end
    endfunction

    // compute the result of one operation and advance the image
    function automatic pts_out_t schedule_op(pts_in_t op);
        pts_out_t r;
        int s;
        int c;
        int w;
        int t;
        int best;
        bit resched;
        bit semop;
        bit none;
        bit found;
        s = op.sem_index;
        c = cur_task;
        resched = 0; semop = 0; none = 0;
        case (op.operation)
            OP_TICK: begin
                for (int k = 0; k < NTASK; k++) begin
                    if (slp[k]) begin
                        slp_left[k] = slp_left[k] - 16'd1;
                        if (slp_left[k] == 0) begin
                            slp[k] = 1'b0;
                            if (blk[k]) begin
                                blk[k] = 1'b0;
                                tmo[k] = 1'b1;
                                if (sem_cnt[wsem[k]] < 32767) sem_cnt[wsem[k]]++;
                                queue_unlink(wsem[k], k);
                            end
                        end
                    end
                end
                resched = 1;
            end
            OP_P, OP_PT: begin
                semop = 1;
                if (op.operation == OP_PT) tmo[c] = 1'b0;
                if (task_ready(c)) begin
                    sem_cnt[s]--;
                    if (sem_cnt[s] < 0) begin
                        wsem[c] = 2'(s);
                        blk[c] = 1'b1;
                        if (op.operation == OP_PT) begin
                            slp[c] = 1'b1;
                            slp_left[c] = op.ticks;
                        end
                        queue_push(s, c);
                        resched = 1;
                    end
                end
            end
            OP_V: begin
                semop = 1;
                if (sem_cnt[s] < 32767) sem_cnt[s]++;
                if (qbusy[s]) begin
                    w = qhead[s];
                    blk[w] = 1'b0;
                    slp[w] = 1'b0;
                    if (qtail[s] == w) qbusy[s] = 1'b0;
                    else qhead[s] = nxt[w];
                    if (prio[w] > prio[c]) resched = 1;
                end
            end
            OP_SLEEP: begin
                if (task_ready(c)) begin
                    slp[c] = 1'b1;
                    slp_left[c] = op.ticks;
                    resched = 1;
                end
            end
            OP_YIELD: resched = 1;
            default: ;
        endcase
        if (resched) begin
            t = c; best = 0; found = 0;
            for (int i = 0; i < NTASK; i++) begin
                t = (t + 1) % NTASK;
                if (task_ready(t) && (!found || prio[t] > prio[best])) begin
                    best = t;
                    found = 1;
                end
            end
            none = !found;
            if (found) cur_task = 2'(best);
        end
        r.running_task = cur_task;
        r.switched = (cur_task != c);
        r.timed_out = tmo[cur_task];
        r.none_ready = none;
        r.sem_value = semop ? sem_cnt[s][15:0] : 16'sd0;
        return r;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic pts_in_t rand_op();
        pts_in_t op;
        int r;
        r = $urandom_range(0, 99);
        op.sem_index = 2'($urandom_range(0, 3));
        if (r < 30) op.operation = OP_TICK;
        else if (r < 45) op.operation = OP_P;
        else if (r < 57) op.operation = OP_PT;
        else if (r < 77) op.operation = OP_V;
        else if (r < 87) op.operation = OP_SLEEP;
        else if (r < 96) op.operation = OP_YIELD;
        else op.operation = 3'($urandom_range(6, 7));
        // short durations mostly so that timeouts and wakeups happen
        if ($urandom_range(0, 15) == 0) op.ticks = 16'($urandom);
        else if ($urandom_range(0, 15) == 0) op.ticks = 16'd0;
        else op.ticks = 16'($urandom_range(1, 6));
        return op;
    endfunction

    // driver: present the oldest pending transaction
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(schedule_op(s_data));
                void'(pending_ops.pop_front());
                gap_left <= rand_gap();
                if (gap_left == 0 && pending_ops.size() > 0 && !hold_tx) begin
                    s_data <= pending_ops[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else if (pending_ops.size() > 0 && !hold_tx) begin
                    s_valid <= 1'b1;
                    s_data <= pending_ops[0];
                end
            end
        end
    end

    // monitor: take results with random backpressure and compare
    always @(posedge aclk) begin
        pts_out_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h actual %h", exp_r, m_data);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left <= rand_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("priority_task_scheduler_semaphores_unit: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // present the write, then update the model after the clock edge; the caller drops cfg_we after the last one
    task automatic write_reg(logic [2:0] idx, logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(posedge aclk);
        model_config(idx, v);
    endtask

    task automatic push_op(logic [2:0] o, logic [1:0] s, logic [15:0] t);
        pts_in_t op;
        op.operation = o;
        op.sem_index = s;
        op.ticks = t;
        pending_ops.push_back(op);
    endtask

    initial begin
        logic [7:0] v;
        model_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: blocking, timeouts, wakeups, wraps, ignored codes
        push_op(OP_YIELD, 0, 0);
        push_op(OP_P, 3, 0);
        push_op(OP_P, 3, 0);
        push_op(OP_V, 3, 0);
        push_op(OP_PT, 0, 16'd2);
        push_op(OP_TICK, 0, 0);
        push_op(OP_TICK, 0, 0);
        push_op(OP_SLEEP, 1, 16'd1);
        push_op(OP_P, 1, 0);
        push_op(OP_P, 1, 0);
        push_op(OP_PT, 1, 16'hFFFF);
        push_op(OP_V, 1, 0);
        push_op(OP_V, 1, 0);
        push_op(OP_TICK, 2, 0);
        push_op(3'd6, 3, 16'hFFFF);
        push_op(3'd7, 0, 0);
        push_op(OP_SLEEP, 0, 16'd0);
        push_op(OP_YIELD, 2, 0);
        push_op(OP_TICK, 0, 0);
        push_op(OP_V, 0, 16'h5555);
        push_op(OP_V, 2, 16'hAAAA);
        wait_drained();

        // random phases under different settings
        for (int ph = 0; ph < 7; ph++) begin
            for (int i = 0; i < NTASK; i++) begin
                case (ph)
                    0: v = 8'd0;
                    1: v = 8'd255;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                if (ph >= 2 && $urandom_range(0, 2) == 0) v = 8'($urandom_range(0, 3));
                write_reg(CFG_PRIO0 + 3'(i), v);
            end
            for (int i = 0; i < NSEM; i++) begin
                case (ph)
                    0: v = 8'd0;
                    1: v = 8'd255;
                    default: v = 8'($urandom_range(0, 3));
                endcase
                write_reg(CFG_START0 + 3'(i), v);
            end
            cfg_we <= 1'b0;
            for (int k = 0; k < 200; k++) begin
                pending_ops.push_back(rand_op());
                if (ph == 3 && k == 100) begin
                    wait_drained();
                    hold_tx = 1'b1;
                    repeat (20) @(posedge aclk);
                    hold_tx = 1'b0;
                end
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("priority_task_scheduler_semaphores_unit: match");
        end else begin
            $display("priority_task_scheduler_semaphores_unit: mismatch");
        end
        $finish;
    end
endmodule

// ----- priority_task_scheduler_semaphores_unit.f -----
+incdir+hdl
hdl/pts_pkg.sv
hdl/pts_datapath.sv
hdl/pts_controller.sv
hdl/priority_task_scheduler_semaphores_unit.sv
sim/priority_task_scheduler_semaphores_unit_test.sv
